// ===== hw/rtl/ordered_list_engine_core_assert.svh =====
// Assertion macros for the ordered list engine.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define OLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OLE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/olist_pkg.sv =====
`default_nettype none

package olist_pkg;

   localparam int CAPACITY_DEF = 128;
   localparam int DATA_W       = 32;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_LOCATE = 2'd2;
   localparam logic [1:0] CMD_GET    = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   // what every cell of the chain does this cycle
   localparam logic [1:0] CELL_HOLD = 2'd0;
   localparam logic [1:0] CELL_INS  = 2'd1;
   localparam logic [1:0] CELL_DEL  = 2'd2;
   localparam logic [1:0] CELL_ROT  = 2'd3;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [7:0]               position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] value_out;
      logic [7:0]               found_position;
      logic [7:0]               count;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/olist_cell.sv =====
`default_nettype none

// One list slot. Insert takes the left neighbor above the insert point,
// delete and rotate take the right neighbor.
module olist_cell #(
   parameter int             IW  = 7,
   parameter logic [IW-1:0]  IDX = '0
) (
   input  wire logic                           clock,
   input  wire olist_pkg::cell_ctrl_type       ctrl,
   input  wire logic [IW-1:0]                  pos,
   input  wire logic [olist_pkg::DATA_W-1:0]   left_data,
   input  wire logic [olist_pkg::DATA_W-1:0]   right_data,
   input  wire logic [olist_pkg::DATA_W-1:0]   new_data,
   output      logic [olist_pkg::DATA_W-1:0]   data_out
);

   logic [olist_pkg::DATA_W-1:0] data_ff;
   logic [olist_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         olist_pkg::CELL_INS: begin
            if (IDX > pos) begin
               data_in = left_data;
            end else if (IDX == pos) begin
               data_in = new_data;
            end
         end
         olist_pkg::CELL_DEL: begin
            if (IDX >= pos) begin
               data_in = right_data;
            end
         end
         olist_pkg::CELL_ROT: begin
            data_in = right_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_list_engine_core.sv =====
`default_nettype none
// Ordered list engine: a list of up to CAPACITY signed 32-bit words with
// 1-based positions, held in a ring of cells.
// Request channel (req_valid, req_stall, req_data): cmd, position, value.
// Response channel (rsp_valid, rsp_stall, rsp_data): status, value_out,
// found_position, count. Exactly one response word per request word.
// Insert shifts the cells above the insert point as it is accepted; its
// response is registered and shows up the cycle after acceptance.
// Delete, locate and get rotate the whole ring once through cell 0, one
// cell per cycle, comparing or capturing at the head, until the ring is
// back in place; a final step then applies a delete shift and loads the
// response once the response register is free.
// Throughput: one insert per cycle while no response is stalled; a delete,
// locate or get blocks all requests until its final step is done.
// A locate, delete or get is taken while an earlier response still waits;
// an insert waits until the response register is free. A stalled response
// holds, and the engine then sits in its final step until it is taken.
// Synchronous reset empties the list (count 0) and drops any response.
`include "ordered_list_engine_core_assert.svh"

module ordered_list_engine_core #(
   parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire olist_pkg::req_type  req_data,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      olist_pkg::rsp_type  rsp_data
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = ((CW > 8) ? CW : 8) + 1;
   localparam int DW = olist_pkg::DATA_W;
   localparam logic [IW-1:0] SCAN_LAST = IW'(CAPACITY - 1);

   localparam logic [1:0] FSM_IDLE = 2'd0;
   localparam logic [1:0] FSM_SCAN = 2'd1;
   localparam logic [1:0] FSM_FIN  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [IW-1:0]       scan_ff, scan_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [DW-1:0]       val_ff, val_in;
   logic [IW-1:0]       pmi_ff, pmi_in;
   logic [1:0]          st_ff, st_in;
   logic                hit_ff, hit_in;
   logic [DW-1:0]       vout_ff, vout_in;
   logic [7:0]          found_ff, found_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   olist_pkg::rsp_type  rsp_ff, rsp_in;

   logic                     req_accept;
   logic                     fin_go;
   logic [WW-1:0]            pos_w, cnt_w, scan_w;
   logic [WW-1:0]            pos_m1_w;
   logic [IW-1:0]            pos_m1;
   logic                     pos_zero;
   logic [1:0]               ins_status, del_status, get_status, req_status;
   logic [CW-1:0]            cnt_fin;
   logic [WW-1:0]            cnt_ins_w, cnt_fin_w, found_w;
   olist_pkg::cell_ctrl_type cell_ctrl;
   logic [IW-1:0]            cell_pos;
   logic [DW-1:0]            cell_data [CAPACITY];
   logic [DW-1:0]            head;

   // ---------------- request decode ----------------
   assign pos_w    = WW'(req_data.position);
   assign cnt_w    = WW'(cnt_ff);
   assign scan_w   = WW'(scan_ff);
   assign pos_zero = (pos_w == '0);
   assign pos_m1_w = pos_w - WW'(1);
   assign pos_m1   = pos_m1_w[IW-1:0];

   always_comb begin
      if (cnt_w >= WW'(CAPACITY)) begin
         ins_status = olist_pkg::ST_FULL;
      end else if (pos_zero || (pos_w > cnt_w + WW'(1))) begin
         ins_status = olist_pkg::ST_RANGE;
      end else begin
         ins_status = olist_pkg::ST_OK;
      end

      if (cnt_w == '0) begin
         del_status = olist_pkg::ST_EMPTY;
      end else if (pos_zero || (pos_w > cnt_w)) begin
         del_status = olist_pkg::ST_RANGE;
      end else begin
         del_status = olist_pkg::ST_OK;
      end

      if (pos_zero || (pos_w > cnt_w)) begin
         get_status = olist_pkg::ST_RANGE;
      end else begin
         get_status = olist_pkg::ST_OK;
      end

      case (req_data.cmd)
         olist_pkg::CMD_INSERT: req_status = ins_status;
         olist_pkg::CMD_DELETE: req_status = del_status;
         olist_pkg::CMD_GET:    req_status = get_status;
         default:               req_status = olist_pkg::ST_OK;
      endcase
   end

   // insert answers at once, so it needs a free response register
   assign req_stall  = (state_ff != FSM_IDLE) ||
                       (rsp_valid_ff && rsp_stall && (req_data.cmd == olist_pkg::CMD_INSERT));
   assign req_accept = req_valid && !req_stall;
   assign fin_go     = (state_ff == FSM_FIN) && (!rsp_valid_ff || !rsp_stall);

   // ---------------- cell chain ----------------
   always_comb begin
      cell_ctrl.op = olist_pkg::CELL_HOLD;
      if (req_accept && (req_data.cmd == olist_pkg::CMD_INSERT) &&
          (ins_status == olist_pkg::ST_OK)) begin
         cell_ctrl.op = olist_pkg::CELL_INS;
      end else if (state_ff == FSM_SCAN) begin
         cell_ctrl.op = olist_pkg::CELL_ROT;
      end else if (fin_go && (cmd_ff == olist_pkg::CMD_DELETE) &&
                   (st_ff == olist_pkg::ST_OK)) begin
         cell_ctrl.op = olist_pkg::CELL_DEL;
      end
   end

   assign cell_pos = (state_ff == FSM_IDLE) ? pos_m1 : pmi_ff;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      olist_cell #(
         .IW  (IW),
         .IDX (IW'(k))
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .pos        (cell_pos),
         .left_data  (cell_data[(k + CAPACITY - 1) % CAPACITY]),
         .right_data (cell_data[(k + 1) % CAPACITY]),
         .new_data   (req_data.value),
         .data_out   (cell_data[k])
      );
   end

   assign head = cell_data[0];

   // ---------------- sequencer ----------------
   assign found_w   = scan_w + WW'(1);
   assign cnt_ins_w = WW'(cnt_ff) + WW'(1);
   assign cnt_fin   = ((cmd_ff == olist_pkg::CMD_DELETE) && (st_ff == olist_pkg::ST_OK)) ?
                      cnt_ff - CW'(1) : cnt_ff;
   assign cnt_fin_w = WW'(cnt_fin);

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      pmi_in       = pmi_ff;
      st_in        = st_ff;
      hit_in       = hit_ff;
      vout_in      = vout_ff;
      found_in     = found_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               if (req_data.cmd == olist_pkg::CMD_INSERT) begin
                  rsp_in.status         = ins_status;
                  rsp_in.value_out      = '0;
                  rsp_in.found_position = '0;
                  if (ins_status == olist_pkg::ST_OK) begin
                     cnt_in              = cnt_ff + CW'(1);
                     rsp_in.count        = cnt_ins_w[7:0];
                  end else begin
                     rsp_in.count        = cnt_w[7:0];
                  end
                  rsp_valid_in = 1'b1;
               end else begin
                  cmd_in   = req_data.cmd;
                  val_in   = req_data.value;
                  pmi_in   = pos_m1;
                  st_in    = req_status;
                  hit_in   = 1'b0;
                  vout_in  = '0;
                  found_in = '0;
                  scan_in  = '0;
                  state_in = FSM_SCAN;
               end
            end
         end
         FSM_SCAN: begin
            // head holds the entry at list index scan_ff
            if (cmd_ff == olist_pkg::CMD_LOCATE) begin
               if (!hit_ff && (scan_w < cnt_w) && (head == val_ff)) begin
                  hit_in   = 1'b1;
                  found_in = found_w[7:0];
               end
            end else if ((st_ff == olist_pkg::ST_OK) && (scan_ff == pmi_ff)) begin
               vout_in = head;
            end
            scan_in = scan_ff + IW'(1);
            if (scan_ff == SCAN_LAST) begin
               scan_in  = '0;
               state_in = FSM_FIN;
            end
         end
         FSM_FIN: begin
            if (fin_go) begin
               cnt_in                = cnt_fin;
               rsp_in.status         = st_ff;
               rsp_in.value_out      = vout_ff;
               rsp_in.found_position = found_ff;
               rsp_in.count          = cnt_fin_w[7:0];
               rsp_valid_in          = 1'b1;
               state_in              = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      cmd_ff   <= cmd_in;
      val_ff   <= val_in;
      pmi_ff   <= pmi_in;
      st_ff    <= st_in;
      hit_ff   <= hit_in;
      vout_ff  <= vout_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- assertions ----------------
   `OLE_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_w <= WW'(CAPACITY), "count above capacity")
   `OLE_ASSERT_NXT(a_ins_cnt, clock, reset, req_accept && (req_data.cmd == olist_pkg::CMD_INSERT) && (ins_status == olist_pkg::ST_OK), cnt_ff == $past(cnt_ff) + CW'(1), "insert did not grow list")
   `OLE_ASSERT_NXT(a_del_cnt, clock, reset, fin_go && (cmd_ff == olist_pkg::CMD_DELETE) && (st_ff == olist_pkg::ST_OK), cnt_ff == $past(cnt_ff) - CW'(1), "delete did not shrink list")
   `OLE_ASSERT_NXT(a_scan_start, clock, reset, req_accept && (req_data.cmd != olist_pkg::CMD_INSERT), (state_ff == FSM_SCAN) && (scan_ff == '0), "scan did not start at head")
   `OLE_ASSERT_NXT(a_scan_end, clock, reset, (state_ff == FSM_SCAN) && (scan_ff == SCAN_LAST), (state_ff == FSM_FIN) && (scan_ff == '0), "ring not restored after sweep")

endmodule

`default_nettype wire
